// ----- rtl/taq_pkg.sv -----
package taq_pkg;

  localparam int TIME_W   = 32;
  localparam int OWNER_W  = 8;
  localparam int ALARM_W  = 4;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_REG       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEREG     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEREG_ALL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MOVE      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // max alarms fired per tick word
  localparam int OUT_LIMIT = 16;
  localparam int BURST_W   = $clog2(OUT_LIMIT + 1);

  typedef struct packed {
    logic [TIME_W-1:0]  tstamp;
    logic [OWNER_W-1:0] owner;
    logic [ALARM_W-1:0] alarm;
  } entry_t;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_KEEP   = 2'd1,
    CM_DROP   = 2'd2,
    CM_APPEND = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    entry_t     tail;
  } cell_cmd_t;

endpackage

// ----- rtl/taq_cell.sv -----
module taq_cell
  import taq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int IDX = 0,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [CW-1:0] count,
  input  entry_t        right_in,
  output entry_t        ent
);

  localparam logic [CW-1:0] POS      = CW'(IDX);
  localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

  entry_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.mode)
      CM_KEEP: begin
        if (POS_NEXT < count) begin
          ent_nxt = right_in;
        end else if (POS_NEXT == count) begin
          ent_nxt = cmd.tail;
        end
      end
      CM_DROP: begin
        if (POS_NEXT < count) begin
          ent_nxt = right_in;
        end
      end
      CM_APPEND: begin
        if (POS == count) begin
          ent_nxt = cmd.tail;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

// ----- rtl/timed_alarm_queue.sv -----
// Sorted alarm queue, up to QUEUE_DEPTH entries in ascending trigger time.
// Input channel (in_*): one word per operation: register, deregister,
// deregister all of an owner, move, tick. Taken only while the block is idle.
// Output channel (out_*): one or more result words per input word, out_last
// set on the final one. A tick fires due alarms from the front, up to 16.
// Entries live in a row of cells that shift toward the head. Register,
// deregister and deregister-all rotate the occupied cells once through the
// head, register also adding the new entry. Move takes two passes, one
// to take the entry out and one to put it back. A tick loads one result
// per cycle into the output register while out_stall is low; a full-queue
// register or an unused kind goes straight from idle to S_FIN instead.
// The block takes the next word the cycle after the last result is loaded
// into the output register, even while that result is still stalled.
// Reset (rst_n low at a clock edge) empties the queue and drops any
// pending result. While out_stall is high the result word holds; a new word
// is still taken and processed, and the block then waits before loading
// its first result.
module timed_alarm_queue
  import taq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [OWNER_W-1:0]  in_owner,
  input  logic [ALARM_W-1:0]  in_alarm_id,
  input  logic [TIME_W-1:0]   in_time_req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_fired,
  output logic [OWNER_W-1:0]  out_fired_owner,
  output logic [ALARM_W-1:0]  out_fired_alarm_id,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_TICK = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [KIND_W-1:0]   op_r, op_nxt;
  logic [OWNER_W-1:0]  own_r, own_nxt;
  logic [ALARM_W-1:0]  alm_r, alm_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [BURST_W-1:0]  k_r, k_nxt;
  logic                ins_r, ins_nxt;
  logic                found_r, found_nxt;
  logic                phase2_r, phase2_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_fired_r;
  logic [OWNER_W-1:0]  out_owner_r;
  logic [ALARM_W-1:0]  out_alarm_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;

  logic                res_load;
  logic                res_fired;
  logic [OWNER_W-1:0]  res_owner;
  logic [ALARM_W-1:0]  res_alarm;
  logic [STATUS_W-1:0] res_status;
  logic                res_last;

  entry_t    ent [QUEUE_DEPTH];
  cell_cmd_t cmd;
  entry_t    head;
  entry_t    new_item;
  logic      out_free;
  logic      drop;

  assign head     = ent[0];
  assign new_item = '{tstamp: time_r, owner: own_r, alarm: alm_r};
  assign out_free = !out_valid_r || !out_stall;
  assign drop     = (((op_r == KIND_DEREG) || (op_r == KIND_MOVE)) && !found_r &&
                     (head.owner == own_r) && (head.alarm == alm_r)) ||
                    ((op_r == KIND_DEREG_ALL) && (head.owner == own_r));

  assign in_stall = (state_r != S_IDLE);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        taq_cell #(.QUEUE_DEPTH(QUEUE_DEPTH), .IDX(g)) u_cell (
          .clk      (clk),
          .cmd      (cmd),
          .count    (n_r),
          .right_in (ent[g]),
          .ent      (ent[g])
        );
      end else begin : g_body
        taq_cell #(.QUEUE_DEPTH(QUEUE_DEPTH), .IDX(g)) u_cell (
          .clk      (clk),
          .cmd      (cmd),
          .count    (n_r),
          .right_in (ent[g+1]),
          .ent      (ent[g])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    own_nxt    = own_r;
    alm_nxt    = alm_r;
    time_nxt   = time_r;
    n_nxt      = n_r;
    rem_nxt    = rem_r;
    k_nxt      = k_r;
    ins_nxt    = ins_r;
    found_nxt  = found_r;
    phase2_nxt = phase2_r;
    status_nxt = status_r;
    cmd.mode   = CM_HOLD;
    cmd.tail   = head;
    res_load   = 1'b0;
    res_fired  = 1'b0;
    res_owner  = '0;
    res_alarm  = '0;
    res_status = STATUS_OK;
    res_last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_kind;
          own_nxt    = in_owner;
          alm_nxt    = in_alarm_id;
          time_nxt   = in_time_req;
          rem_nxt    = n_r;
          k_nxt      = '0;
          ins_nxt    = 1'b0;
          found_nxt  = 1'b0;
          phase2_nxt = 1'b0;
          status_nxt = STATUS_OK;
          case (in_kind)
            KIND_REG: begin
              if (n_r == CW'(QUEUE_DEPTH)) begin
                status_nxt = STATUS_FULL;
                state_nxt  = S_FIN;
              end else begin
                ins_nxt   = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            KIND_DEREG, KIND_DEREG_ALL, KIND_MOVE: begin
              state_nxt = S_SCAN;
            end
            KIND_TICK: begin
              state_nxt = S_TICK;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rem_r != '0) begin
          if (ins_r && (head.tstamp > time_r)) begin
            cmd.mode = CM_APPEND;
            cmd.tail = new_item;
            n_nxt    = n_r + 1'b1;
            ins_nxt  = 1'b0;
          end else if (drop) begin
            cmd.mode  = CM_DROP;
            n_nxt     = n_r - 1'b1;
            rem_nxt   = rem_r - 1'b1;
            found_nxt = 1'b1;
          end else begin
            cmd.mode = CM_KEEP;
            rem_nxt  = rem_r - 1'b1;
          end
        end else if (ins_r) begin
          cmd.mode  = CM_APPEND;
          cmd.tail  = new_item;
          n_nxt     = n_r + 1'b1;
          ins_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else if ((op_r == KIND_MOVE) && found_r && !phase2_r) begin
          // matching entry is out, now put it back at the new time
          phase2_nxt = 1'b1;
          ins_nxt    = 1'b1;
          rem_nxt    = n_r;
        end else begin
          if (((op_r == KIND_DEREG) || (op_r == KIND_MOVE)) && !found_r) begin
            status_nxt = STATUS_NOT_FOUND;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = status_r;
          state_nxt  = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free) begin
          res_load = 1'b1;
          if ((n_r != '0) && (head.tstamp <= time_r)) begin
            res_fired = 1'b1;
            res_owner = head.owner;
            res_alarm = head.alarm;
            res_last  = !((n_r > CW'(1)) && (ent[1].tstamp <= time_r)) ||
                        (k_r == BURST_W'(OUT_LIMIT - 1));
            cmd.mode  = CM_DROP;
            n_nxt     = n_r - 1'b1;
            k_nxt     = k_r + 1'b1;
          end
          if (res_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= KIND_REG;
      n_r         <= '0;
      rem_r       <= '0;
      k_r         <= '0;
      ins_r       <= 1'b0;
      found_r     <= 1'b0;
      phase2_r    <= 1'b0;
      status_r    <= STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      n_r         <= n_nxt;
      rem_r       <= rem_nxt;
      k_r         <= k_nxt;
      ins_r       <= ins_nxt;
      found_r     <= found_nxt;
      phase2_r    <= phase2_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    own_r  <= own_nxt;
    alm_r  <= alm_nxt;
    time_r <= time_nxt;
    if (res_load) begin
      out_fired_r  <= res_fired;
      out_owner_r  <= res_owner;
      out_alarm_r  <= res_alarm;
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fired          = out_fired_r;
  assign out_fired_owner    = out_owner_r;
  assign out_fired_alarm_id = out_alarm_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted word not processed");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (n_r > CW'(1))) |-> (ent[0].tstamp <= ent[1].tstamp))
    else $error("queue head out of order");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fired_r) |-> (out_status_r == STATUS_OK))
    else $error("fired word with error status");

endmodule
